[rtl/line_follow_pid_controller_top_assert.svh]
// Assertion macros shared by the checker of the line follower PID controller.
`ifndef LINE_FOLLOW_PID_CONTROLLER_TOP_ASSERT_SVH
`define LINE_FOLLOW_PID_CONTROLLER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LFPID_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LFPID_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/lfpid_pkg.sv]
// Shared types, constants and register codes of the line follower PID controller.
package lfpid_pkg;

   localparam int NumLanes  = 4;
   localparam int RawW      = 8;
   localparam int LevelW    = 7;
   localparam int GainW     = 24;
   localparam int IntegW    = 24;
   localparam int ErrW      = 8;
   localparam int CorrW     = 7;
   localparam int FracBits  = 16;
   localparam int ReqDataW  = NumLanes * RawW;
   localparam int RspDataW  = 24;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 24;

   localparam int FullScale  = 100;
   localparam int CentreLow  = 40;
   localparam int OnLineLow  = 70;
   localparam int HighLevel  = 80;
   localparam int CornerErr  = 60;
   localparam int LostErr    = 100;
   localparam int OutLimit   = 50;
   localparam int CorrMagW   = 6;

   localparam logic [NumLanes-1:0][RawW-1:0] MaxReset = {8'd47, 8'd48, 8'd47, 8'd52};
   localparam logic [GainW-1:0] GainPropReset  = 24'd29491;
   localparam logic [GainW-1:0] GainIntegReset = 24'd98;
   localparam logic [GainW-1:0] GainDerivReset = 24'd589824;

   typedef enum logic [CsrIndexW-1:0] {
      CsrMaxLeftOuter  = 3'd0,
      CsrMaxLeftInner  = 3'd1,
      CsrMaxRightInner = 3'd2,
      CsrMaxRightOuter = 3'd3,
      CsrGainProp      = 3'd4,
      CsrGainInteg     = 3'd5,
      CsrGainDeriv     = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      TrackOnLine = 2'd0,
      TrackCorner = 2'd1,
      TrackLost   = 2'd2
   } track_mode_type;

   typedef enum logic [1:0] {
      DirNone  = 2'd0,
      DirRight = 2'd1,
      DirLeft  = 2'd2
   } turn_dir_type;

   typedef struct packed {
      logic [LevelW-1:0] level;
      logic              zero;
   } lane_res_type;

   typedef struct packed {
      logic                    start;
      logic                    ack;
   } merge_ctl_type;

   // Packed so that line_error sits in the lowest bits.
   typedef struct packed {
      logic [2:0]              pad;
      logic [3:0]              zero_flags;
      logic signed [CorrW-1:0] correction;
      logic [1:0]              track_mode;
      logic signed [ErrW-1:0]  line_error;
   } rsp_item_type;

endpackage

[rtl/line_follow_pid_controller_top.sv]
// Top level of the line follower PID controller: registers, lanes, merge and output stage.
//
// Usage:
//  - req_* takes one item of four raw reflectance samples; rsp_* returns one
//    result item per accepted item, in order.
//  - csr_* writes a calibration level or a gain; write only while idle.
//    csr_ready is always high; an index past the gain registers is dropped.
//  - Path: the four divider lanes (two quotient bits a cycle), then the
//    merge stage (classify, multiply, sum, clamp), then the output register.
//  - Flow: one item at a time; req_tready returns high at the edge that
//    moves the result into the output register.
//  - Stall: a result waits in the output register while rsp_tready is low;
//    the next item is still taken and worked, and holds in the merge stage
//    until the output register frees.
//  - Reset: clears the turn memory, the integral and the previous error,
//    loads the default calibration levels and gains, and empties the output.
module line_follow_pid_controller_top (
   input  logic                              clock,
   input  logic                              reset,
   // raw_left_outer, raw_left_inner, raw_right_inner, raw_right_outer
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lfpid_pkg::ReqDataW-1:0]    req_tdata,
   // line_error, track_mode, correction, zero_flags, zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lfpid_pkg::RspDataW-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lfpid_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [lfpid_pkg::CsrDataW-1:0]    csr_data
);
   import lfpid_pkg::*;

   // calibration and gain registers
   logic [NumLanes-1:0][RawW-1:0] max_ff, max_in;
   logic [GainW-1:0]              gain_p_ff, gain_p_in;
   logic [GainW-1:0]              gain_i_ff, gain_i_in;
   logic [GainW-1:0]              gain_d_ff, gain_d_in;

   // item in flight and output stage
   logic                          busy_ff, busy_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_item_type                  rsp_data_ff, rsp_data_in;

   lane_res_type [NumLanes-1:0]   lane_res;
   logic [NumLanes-1:0]           lane_done;
   merge_ctl_type                 mg_ctl;
   logic                          mg_done;
   rsp_item_type                  mg_result;
   logic                          accept;
   logic                          csr_write;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   // decode register writes; unknown indexes fall through the default arm
   always_comb begin
      max_in    = max_ff;
      gain_p_in = gain_p_ff;
      gain_i_in = gain_i_ff;
      gain_d_in = gain_d_ff;
      if (csr_write) begin
         case (csr_index)
            CsrMaxLeftOuter:  max_in[0] = csr_data[RawW-1:0];
            CsrMaxLeftInner:  max_in[1] = csr_data[RawW-1:0];
            CsrMaxRightInner: max_in[2] = csr_data[RawW-1:0];
            CsrMaxRightOuter: max_in[3] = csr_data[RawW-1:0];
            CsrGainProp:      gain_p_in = csr_data[GainW-1:0];
            CsrGainInteg:     gain_i_in = csr_data[GainW-1:0];
            CsrGainDeriv:     gain_d_in = csr_data[GainW-1:0];
            default: begin
            end
         endcase
      end
   end

   // one scaling lane per sensor, all started by the accepted item
   for (genvar g = 0; g < NumLanes; g++) begin : g_lane
      lfpid_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .start     (accept),
         .raw       (req_tdata[g*RawW +: RawW]),
         .max_level (max_ff[g]),
         .result    (lane_res[g]),
         .done      (lane_done[g])
      );
   end

   // lanes run in lockstep, so lane zero's finish starts the merge
   assign mg_ctl.start = lane_done[0];
   assign mg_ctl.ack   = mg_done && (!rsp_valid_ff || rsp_tready);

   lfpid_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mg_ctl),
      .lanes      (lane_res),
      .gain_prop  (gain_p_ff),
      .gain_integ (gain_i_ff),
      .gain_deriv (gain_d_ff),
      .done       (mg_done),
      .result     (mg_result)
   );

   // output register: load on merge hand-off, drop on receiver take
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      busy_in      = busy_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (mg_ctl.ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = mg_result;
         busy_in      = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= MaxReset;
         gain_p_ff    <= GainPropReset;
         gain_i_ff    <= GainIntegReset;
         gain_d_ff    <= GainDerivReset;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_ff       <= max_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/lfpid_lane.sv]
// One scaling lane: raw * 100 / max with clamp to 100, two quotient bits a cycle.
module lfpid_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lfpid_pkg::RawW-1:0]   raw,
   input  logic [lfpid_pkg::RawW-1:0]   max_level,
   output lfpid_pkg::lane_res_type      result,
   output logic                         done
);
   import lfpid_pkg::*;

   localparam int RemW = 15;
   localparam int QuoW = 8;

   logic [RemW-1:0] rem_ff, rem_in;
   logic [RemW-1:0] div_ff, div_in;
   logic [QuoW-1:0] quo_ff, quo_in;
   logic            sat_ff, sat_in;
   logic [1:0]      step_ff, step_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;

   logic [RawW-1:0] eff_max;
   logic [RemW-1:0] prod;
   logic [RemW-1:0] rem_a, div_b, rem_b;
   logic            ge_a, ge_b;

   always_comb begin
      eff_max = (max_level == '0) ? RawW'(1) : max_level;
      prod    = RemW'({raw, 6'b0}) + RemW'({raw, 5'b0}) + RemW'({raw, 2'b0});

      ge_a  = (rem_ff >= div_ff);
      rem_a = ge_a ? (rem_ff - div_ff) : rem_ff;
      div_b = div_ff >> 1;
      ge_b  = (rem_a >= div_b);
      rem_b = ge_b ? (rem_a - div_b) : rem_a;

      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;

      if (start) begin
         // a sample at or above its white level scales to at least 100
         rem_in  = prod;
         div_in  = RemW'({eff_max, 7'b0});
         quo_in  = '0;
         sat_in  = (raw >= eff_max);
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in  = rem_b;
         div_in  = div_b >> 1;
         quo_in  = {quo_ff[QuoW-3:0], ge_a, ge_b};
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign result.level = sat_ff ? LevelW'(FullScale) : quo_ff[LevelW-1:0];
   assign result.zero  = !sat_ff && (quo_ff == '0);
   assign done         = done_ff;

endmodule

[rtl/lfpid_merge.sv]
// Merging stage: classification, turn memory, error value and the PID sequence.
module lfpid_merge (
   input  logic                                            clock,
   input  logic                                            reset,
   input  lfpid_pkg::merge_ctl_type                        ctl,
   input  lfpid_pkg::lane_res_type [lfpid_pkg::NumLanes-1:0] lanes,
   input  logic [lfpid_pkg::GainW-1:0]                     gain_prop,
   input  logic [lfpid_pkg::GainW-1:0]                     gain_integ,
   input  logic [lfpid_pkg::GainW-1:0]                     gain_deriv,
   output logic                                            done,
   output lfpid_pkg::rsp_item_type                         result
);
   import lfpid_pkg::*;

   localparam int AccW   = 50;
   localparam int ProdPW = GainW + 1 + ErrW;
   localparam int ProdIW = GainW + 1 + IntegW;
   localparam int ProdDW = GainW + 1 + ErrW + 1;
   localparam int SumW   = 11;
   localparam logic signed [AccW-1:0] AccLim = AccW'(OutLimit * (1 << FracBits));
   localparam logic signed [IntegW:0] IntegMax = (IntegW+1)'((1 << (IntegW-1)) - 1);
   localparam logic signed [IntegW:0] IntegMin = (IntegW+1)'(-(1 << (IntegW-1)));

   typedef enum logic [2:0] {
      MgIdle, MgMul, MgSum, MgClamp, MgHold
   } mg_state_type;

   mg_state_type              state_ff, state_in;
   logic                      centre_ff, centre_in;
   turn_dir_type              dir_ff, dir_in;
   logic signed [IntegW-1:0]  integ_ff, integ_in;
   logic signed [ErrW-1:0]    prev_ff, prev_in;
   logic signed [ErrW-1:0]    err_ff, err_in;
   logic signed [ErrW:0]      deriv_ff, deriv_in;
   track_mode_type            mode_ff, mode_in;
   logic [NumLanes-1:0]       flags_ff, flags_in;
   logic signed [ProdPW-1:0]  prod_p_ff, prod_p_in;
   logic signed [ProdIW-1:0]  prod_i_ff, prod_i_in;
   logic signed [ProdDW-1:0]  prod_d_ff, prod_d_in;
   logic signed [AccW-1:0]    acc_ff, acc_in;
   rsp_item_type              res_ff, res_in;

   logic [LevelW-1:0]         lv_a, lv_b, lv_c, lv_d;
   logic                      all_low, all_high, corner_left, corner_right;
   logic                      centre_now;
   logic signed [SumW-1:0]    wsum, wq;
   logic signed [ErrW-1:0]    err_pos, err_new;
   logic signed [IntegW:0]    integ_add;
   logic signed [IntegW-1:0]  integ_sat;
   logic [AccW-1:0]           acc_mag;
   logic [CorrMagW-1:0]       corr_mag;
   logic signed [CorrW-1:0]   corr;

   always_comb begin
      lv_a = lanes[0].level;
      lv_b = lanes[1].level;
      lv_c = lanes[2].level;
      lv_d = lanes[3].level;

      all_low  = (lv_a < LevelW'(OnLineLow)) && (lv_b < LevelW'(OnLineLow)) &&
                 (lv_c < LevelW'(OnLineLow)) && (lv_d < LevelW'(OnLineLow));
      all_high = (lv_a > LevelW'(HighLevel)) && (lv_b > LevelW'(HighLevel)) &&
                 (lv_c > LevelW'(HighLevel)) && (lv_d > LevelW'(HighLevel));
      corner_left  = (lv_b > LevelW'(HighLevel)) && (lv_c > LevelW'(HighLevel)) &&
                     (lv_a > LevelW'(HighLevel));
      corner_right = (lv_b > LevelW'(HighLevel)) && (lv_c > LevelW'(HighLevel)) &&
                     (lv_d > LevelW'(HighLevel));

      // weighted position, then divide by four rounding toward zero
      wsum = SumW'(({4'b0, lv_d} << 1) + {4'b0, lv_d} + {4'b0, lv_c}) -
             SumW'(({4'b0, lv_a} << 1) + {4'b0, lv_a} + {4'b0, lv_b});
      wq   = wsum[SumW-1] ? ((wsum + SumW'(3)) >>> 2) : (wsum >>> 2);
      err_pos = ErrW'(wq);

      centre_now = centre_ff || (lv_b < LevelW'(CentreLow)) || (lv_c < LevelW'(CentreLow));

      integ_add = {integ_ff[IntegW-1], integ_ff} + (IntegW+1)'(err_pos);
      if (integ_add > IntegMax) begin
         integ_sat = IntegW'(IntegMax);
      end else if (integ_add < IntegMin) begin
         integ_sat = IntegW'(IntegMin);
      end else begin
         integ_sat = integ_add[IntegW-1:0];
      end

      state_in  = state_ff;
      centre_in = centre_ff;
      dir_in    = dir_ff;
      integ_in  = integ_ff;
      prev_in   = prev_ff;
      err_in    = err_ff;
      deriv_in  = deriv_ff;
      mode_in   = mode_ff;
      flags_in  = flags_ff;
      prod_p_in = prod_p_ff;
      prod_i_in = prod_i_ff;
      prod_d_in = prod_d_ff;
      acc_in    = acc_ff;
      res_in    = res_ff;
      err_new   = '0;

      acc_mag  = acc_ff[AccW-1] ? AccW'(-acc_ff) : AccW'(acc_ff);
      corr_mag = acc_mag[FracBits+CorrMagW-1:FracBits];
      if (acc_ff > AccLim) begin
         corr = CorrW'(OutLimit);
      end else if (acc_ff < -AccLim) begin
         corr = CorrW'(-OutLimit);
      end else if (acc_ff[AccW-1]) begin
         corr = CorrW'(CorrW'(0) - {1'b0, corr_mag});
      end else begin
         corr = CorrW'({1'b0, corr_mag});
      end

      case (state_ff)
         MgIdle: begin
            if (ctl.start) begin
               // turn memory: centre sees the line, then an outer sensor does
               centre_in = centre_now;
               if (centre_now) begin
                  if (lv_a < LevelW'(CentreLow)) begin
                     dir_in    = DirRight;
                     centre_in = 1'b0;
                  end else if (lv_d < LevelW'(CentreLow)) begin
                     dir_in    = DirLeft;
                     centre_in = 1'b0;
                  end
               end

               integ_in = '0;
               if (all_low) begin
                  mode_in = TrackOnLine;
                  err_new = '0;
               end else if (all_high) begin
                  mode_in = TrackLost;
                  case (dir_ff)
                     DirRight: err_new = ErrW'(LostErr);
                     DirLeft:  err_new = ErrW'(-LostErr);
                     default:  err_new = '0;
                  endcase
               end else if (corner_left) begin
                  mode_in = TrackCorner;
                  err_new = ErrW'(-CornerErr);
               end else if (corner_right) begin
                  mode_in = TrackCorner;
                  err_new = ErrW'(CornerErr);
               end else begin
                  mode_in  = TrackOnLine;
                  err_new  = err_pos;
                  integ_in = integ_sat;
               end

               err_in   = err_new;
               deriv_in = (ErrW+1)'(err_new) - (ErrW+1)'(prev_ff);
               prev_in  = err_new;
               for (int i = 0; i < NumLanes; i++) begin
                  flags_in[i] = lanes[i].zero;
               end
               state_in = MgMul;
            end
         end
         MgMul: begin
            prod_p_in = $signed({1'b0, gain_prop}) * err_ff;
            prod_i_in = $signed({1'b0, gain_integ}) * integ_ff;
            prod_d_in = $signed({1'b0, gain_deriv}) * deriv_ff;
            state_in  = MgSum;
         end
         MgSum: begin
            acc_in   = AccW'(prod_p_ff) + AccW'(prod_i_ff) + AccW'(prod_d_ff);
            state_in = MgClamp;
         end
         MgClamp: begin
            res_in.pad        = '0;
            res_in.zero_flags = flags_ff;
            res_in.correction = corr;
            res_in.track_mode = mode_ff;
            res_in.line_error = err_ff;
            state_in          = MgHold;
         end
         MgHold: begin
            if (ctl.ack) begin
               state_in = MgIdle;
            end
         end
         default: begin
            state_in = MgIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= MgIdle;
         centre_ff <= 1'b0;
         dir_ff    <= DirNone;
         integ_ff  <= '0;
         prev_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         centre_ff <= centre_in;
         dir_ff    <= dir_in;
         integ_ff  <= integ_in;
         prev_ff   <= prev_in;
      end
      err_ff    <= err_in;
      deriv_ff  <= deriv_in;
      mode_ff   <= mode_in;
      flags_ff  <= flags_in;
      prod_p_ff <= prod_p_in;
      prod_i_ff <= prod_i_in;
      prod_d_ff <= prod_d_in;
      acc_ff    <= acc_in;
      res_ff    <= res_in;
   end

   assign done   = (state_ff == MgHold);
   assign result = res_ff;

endmodule

[rtl/lfpid_check.sv]
// Port checker of the line follower PID controller and its bind to the top level.
`include "line_follow_pid_controller_top_assert.svh"

module lfpid_check (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [lfpid_pkg::RspDataW-1:0] rsp_tdata
);
   import lfpid_pkg::*;

   rsp_item_type rsp_item;

   assign rsp_item = rsp_item_type'(rsp_tdata);

   // one item in flight: the input closes right after an item is taken
   `LFPID_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "item accepted while busy")

   `LFPID_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `LFPID_ASSERT_SAME(a_corr_range, rsp_tvalid, (rsp_item.correction <= 7'sd50) && (rsp_item.correction >= -7'sd50), "correction out of range")

   `LFPID_ASSERT_SAME(a_corner_err, rsp_tvalid && (rsp_item.track_mode == TrackCorner), (rsp_item.line_error == 8'sd60) || (rsp_item.line_error == -8'sd60), "corner error not sixty")

endmodule

bind line_follow_pid_controller_top lfpid_check u_lfpid_check (.*);
